FILE: design/indexed_sequence_store_core_assert.svh
// ----------------------------------------------------------------------------
// indexed_sequence_store_core assertion macros
// Concurrent assertion shorthands clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH

// Plain property, checked outside reset.
`define ISSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define ISSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the indexed sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_WRITE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e                  action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         count;
  } rsp_t;

endpackage

FILE: design/iss_ram.sv
// ----------------------------------------------------------------------------
// iss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/indexed_sequence_store_core.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store_core
// Ordered sequence of up to CAPACITY signed 32-bit values with indexed
// insert, remove, read and overwrite.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on res_o for exactly one cycle with done_o high and cannot be held
// off, so the receiver must take it in that cycle. With n the element count
// and p the position: overwrite and any rejected request give their result
// the cycle after the transfer and never raise busy; a read goes through the
// RAM read register and ST_FIN; a remove reads p to n-1 in ST_REM_SHIFT, then
// ST_FIN; an insert shifts n-1 down to p up in ST_INS_SHIFT, skipped if p is n,
// then writes in ST_INS_PUT. The element RAM has one read and one write port,
// so the shift moves one entry per cycle through the read register, stepped
// by a single shared address counter. busy is low again in the cycle the
// result is shown, so a new request may be taken alongside it. The element
// RAM has no reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "indexed_sequence_store_core_assert.svh"

module indexed_sequence_store_core #(
  parameter int unsigned CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  iss_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output iss_pkg::rsp_t res_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
  localparam int unsigned DW = iss_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_REM_SHIFT,
    ST_FIN
  } state_e;

  // low 7 bits of a count, for the result field
  function automatic logic [iss_pkg::POS_W-1:0] count7(logic [CW-1:0] c);
    logic [CW+iss_pkg::POS_W-1:0] e;
    e = {{iss_pkg::POS_W{1'b0}}, c};
    return e[iss_pkg::POS_W-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;     // element count
  logic [CW-1:0]   cur_q, cur_d;     // shift cursor
  logic [CW-1:0]   pos_q, pos_d;
  logic [DW-1:0]   val_q, val_d;
  logic            pend_q, pend_d;   // read data due to be written back
  logic [AW-1:0]   wa_q, wa_d;       // its target address
  logic [AW-1:0]   ra_q, ra_d;       // last shift read address
  logic            cap_q, cap_d;     // read data is the result value
  logic [DW-1:0]   data_q, data_d;
  logic            dec_q, dec_d;     // finish removes one element
  logic            done_q, done_d;
  iss_pkg::rsp_t   res_q, res_d;

  // shared cursor step unit
  logic            down;
  logic [CW-1:0]   step;

  logic [PW-1:0]   pos_w, cnt_w;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;

  assign pos_w = PW'(req_i.position);
  assign cnt_w = PW'(cnt_q);
  assign down  = (state_q == ST_INS_SHIFT);
  assign step  = cur_q + (down ? {CW{1'b1}} : CW'(1));

  iss_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    pos_d     = pos_q;
    val_d     = val_q;
    pend_d    = 1'b0;
    wa_d      = wa_q;
    ra_d      = ra_q;
    cap_d     = 1'b0;
    data_d    = cap_q ? ram_rdata : data_q;
    dec_d     = dec_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_re    = 1'b0;
    ram_raddr = cur_q[AW-1:0];
    // pending write-back of a shifted entry always has the write port
    ram_we    = pend_q;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.action == iss_pkg::ACT_INSERT) begin
            if (pos_w > cnt_w) begin
              done_d = 1'b1;
              res_d  = '{iss_pkg::STS_RANGE, '0, count7(cnt_q)};
            end else if (cnt_q == CW'(CAPACITY)) begin
              done_d = 1'b1;
              res_d  = '{iss_pkg::STS_FULL, '0, count7(cnt_q)};
            end else begin
              pos_d   = pos_w[CW-1:0];
              val_d   = req_i.value;
              cur_d   = cnt_q;
              state_d = (pos_w == cnt_w) ? ST_INS_PUT : ST_INS_SHIFT;
            end
          end else if (pos_w >= cnt_w) begin
            done_d = 1'b1;
            res_d  = '{iss_pkg::STS_RANGE, '0, count7(cnt_q)};
          end else begin
            unique case (req_i.action)
              iss_pkg::ACT_REMOVE: begin
                pos_d   = pos_w[CW-1:0];
                cur_d   = pos_w[CW-1:0];
                dec_d   = 1'b1;
                state_d = ST_REM_SHIFT;
              end
              iss_pkg::ACT_READ: begin
                ram_re    = 1'b1;
                ram_raddr = pos_w[AW-1:0];
                cap_d     = 1'b1;
                dec_d     = 1'b0;
                state_d   = ST_FIN;
              end
              default: begin
                // overwrite in place
                ram_we    = 1'b1;
                ram_waddr = pos_w[AW-1:0];
                ram_wdata = req_i.value;
                done_d    = 1'b1;
                res_d     = '{iss_pkg::STS_DONE, '0, count7(cnt_q)};
              end
            endcase
          end
        end
      end

      ST_INS_SHIFT: begin
        // move entry cur-1 up to cur
        ram_re    = 1'b1;
        ram_raddr = step[AW-1:0];
        pend_d    = 1'b1;
        wa_d      = cur_q[AW-1:0];
        cur_d     = step;
        if (step == pos_q) begin
          state_d = ST_INS_PUT;
        end
      end

      ST_INS_PUT: begin
        if (!pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = val_q;
          cnt_d     = cnt_q + CW'(1);
          done_d    = 1'b1;
          res_d     = '{iss_pkg::STS_DONE, '0, count7(cnt_q + CW'(1))};
          state_d   = ST_IDLE;
        end
      end

      ST_REM_SHIFT: begin
        // first read is the removed value, the rest move down by one
        ram_re    = 1'b1;
        ram_raddr = cur_q[AW-1:0];
        ra_d      = cur_q[AW-1:0];
        if (cur_q == pos_q) begin
          cap_d = 1'b1;
        end else begin
          pend_d = 1'b1;
          wa_d   = ra_q;
        end
        cur_d = step;
        if (step == cnt_q) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        cnt_d   = dec_q ? (cnt_q - CW'(1)) : cnt_q;
        done_d  = 1'b1;
        res_d   = '{iss_pkg::STS_DONE, cap_q ? ram_rdata : data_q, count7(cnt_d)};
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
      pos_q   <= '0;
      val_q   <= '0;
      pend_q  <= 1'b0;
      wa_q    <= '0;
      ra_q    <= '0;
      cap_q   <= 1'b0;
      data_q  <= '0;
      dec_q   <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      pos_q   <= pos_d;
      val_q   <= val_d;
      pend_q  <= pend_d;
      wa_q    <= wa_d;
      ra_q    <= ra_d;
      cap_q   <= cap_d;
      data_q  <= data_d;
      dec_q   <= dec_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  `ISSC_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "element count above capacity")
  `ISSC_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_q, "write-back left pending in idle")
  `ISSC_ASSERT_IMP(a_cap_state, cap_q, state_q == ST_REM_SHIFT || state_q == ST_FIN, "stray capture")
  `ISSC_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE, "result shown while busy")

endmodule
